// ===== src/lfsr_noise_sound_channel_defines.svh =====
// Assertion macros for the noise sound channel.
`ifndef LFSR_NOISE_SOUND_CHANNEL_DEFINES_SVH
`define LFSR_NOISE_SOUND_CHANNEL_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LNSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LNSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lnsc_pkg.sv =====
// Package: item types, codes and the divisor table of the noise sound channel.
`timescale 1ns / 1ps
`default_nettype none

package lnsc_pkg;

    // operation codes
    localparam logic [2:0] OP_WRITE    = 3'd0;
    localparam logic [2:0] OP_READ     = 3'd1;
    localparam logic [2:0] OP_TICK     = 3'd2;
    localparam logic [2:0] OP_LENGTH   = 3'd3;
    localparam logic [2:0] OP_ENVELOPE = 3'd4;

    // register indexes
    localparam logic [1:0] REG_LENGTH   = 2'd0;
    localparam logic [1:0] REG_ENVELOPE = 2'd1;
    localparam logic [1:0] REG_POLY     = 2'd2;
    localparam logic [1:0] REG_CONTROL  = 2'd3;

    localparam int unsigned LENGTH_FULL_DEF = 64;

    localparam int unsigned DIV_W    = 7;                // largest divisor is 112
    localparam int unsigned PERIOD_W = DIV_W + 15;       // divisor << 0..15
    localparam int unsigned CNT_W    = 23;               // period countdown
    localparam int unsigned ACC_W    = CNT_W + 1;        // countdown minus clocks, signed
    localparam int unsigned LFSR_W   = 15;

    localparam logic [LFSR_W-1:0] LFSR_SEED   = 15'h7FFF;
    localparam logic [7:0]        RD_LENGTH   = 8'hFF;
    localparam logic [5:0]        RD_CTRL_LOW = 6'h3F;
    localparam logic [3:0]        VOL_MAX     = 4'd15;

    typedef struct packed {
        logic [2:0] operation;
        logic [1:0] reg_select;
        logic [7:0] write_data;
        logic [7:0] tick_cycles;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       channel_on;
        logic [3:0] amplitude;
    } t_out_item;

    function automatic logic [DIV_W-1:0] f_div_base(input logic [2:0] sel);
        logic [DIV_W-1:0] d;
        unique case (sel)
            3'd0:    d = 7'd8;
            3'd1:    d = 7'd16;
            3'd2:    d = 7'd32;
            3'd3:    d = 7'd48;
            3'd4:    d = 7'd64;
            3'd5:    d = 7'd80;
            3'd6:    d = 7'd96;
            default: d = 7'd112;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== src/lfsr_noise_sound_channel.sv =====
// Noise sound channel: four byte registers, 15-bit LFSR, length and envelope units.
`timescale 1ns / 1ps
`default_nettype none

`include "lfsr_noise_sound_channel_defines.svh"

// Noise sound channel with four byte registers (length, envelope, polynomial,
// control). Each input item is one operation: a register write, a register
// read, a tick of tick_cycles clocks, a length clock or an envelope clock, and
// each gives exactly one result item carrying the read data (zero unless a
// read), the channel-on flag and a raw 0..15 amplitude (volume while running
// and LFSR bit 0 is low, else 0). Items are handled one at a time: the input
// is stalled from acceptance until the result has been placed in the output
// register. A write, read, length or envelope item passes from acceptance
// through the execute and result states into the output register, and the
// next item can be accepted once the sequencer is back in idle. A tick on a
// running channel adds a countdown check and one LFSR step per expiry in the
// tick state, because one shared adder adds the timer period to the running
// countdown once per expiry. The output register lets the next item be
// accepted while a finished result still waits on i_stall. Reset is
// synchronous and clears all channel state; the channel is off after reset.
module lfsr_noise_sound_channel
    import lnsc_pkg::*;
#(
    parameter int unsigned LENGTH_FULL = LENGTH_FULL_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    // input item channel
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_item  i_item,
    // result item channel
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_item      o_item
);

    // length counter width: must hold LENGTH_FULL itself
    localparam int unsigned LEN_W = $clog2(LENGTH_FULL + 1);
    // compare width for the length write (6-bit data against LENGTH_FULL)
    localparam int unsigned LCMP_W = (LEN_W > 6) ? LEN_W : 6;

    // sequencer codes
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_TICK   = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0]          r_state, n_state;
    t_in_item            r_item;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out_item, n_out_item;

    // channel state
    logic [LEN_W-1:0]    r_length_count, n_length_count;
    logic                r_length_stop, n_length_stop;
    logic [3:0]          r_env_start, n_env_start;
    logic                r_env_rising, n_env_rising;
    logic [2:0]          r_env_period, n_env_period;
    logic [3:0]          r_period_shift, n_period_shift;
    logic                r_narrow, n_narrow;
    logic [2:0]          r_div_sel, n_div_sel;
    logic                r_running, n_running;
    logic [2:0]          r_env_count, n_env_count;
    logic [3:0]          r_volume, n_volume;
    logic [CNT_W-1:0]    r_countdown, n_countdown;
    logic [LFSR_W-1:0]   r_lfsr, n_lfsr;

    // tick accumulator: countdown minus clocks, two's complement
    logic [ACC_W-1:0]    r_acc, n_acc;

    logic [PERIOD_W-1:0] period;
    logic                acc_le_zero;
    logic                lfsr_fb;
    logic [LFSR_W-1:0]   lfsr_stepped;
    logic [LCMP_W-1:0]   len_data;
    logic [LCMP_W-1:0]   len_full_c;
    logic [2:0]          env_count_dec;
    logic [7:0]          rd_value;

    // shared period shifter
    assign period = PERIOD_W'(f_div_base(r_div_sel)) << r_period_shift;

    assign acc_le_zero = r_acc[ACC_W-1] || (r_acc == '0);

    // one LFSR step: XOR of the two low bits goes to bit 14 (and bit 6 if narrow)
    always_comb begin
        lfsr_fb      = r_lfsr[0] ^ r_lfsr[1];
        lfsr_stepped = {lfsr_fb, r_lfsr[LFSR_W-1:1]};
        if (r_narrow) begin
            lfsr_stepped[6] = lfsr_fb;
        end
    end

    assign len_data      = LCMP_W'(r_item.write_data[5:0]);
    assign len_full_c    = LCMP_W'(LENGTH_FULL);
    assign env_count_dec = (r_env_count != 3'd0) ? (r_env_count - 3'd1) : r_env_count;

    // read-back mux
    always_comb begin
        unique case (r_item.reg_select)
            REG_LENGTH:   rd_value = RD_LENGTH;
            REG_ENVELOPE: rd_value = {r_env_start, r_env_rising, r_env_period};
            REG_POLY:     rd_value = {r_period_shift, r_narrow, r_div_sel};
            default:      rd_value = {1'b1, r_length_stop, RD_CTRL_LOW};
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    always_comb begin
        n_state        = r_state;
        n_out_valid    = r_out_valid;
        n_out_item     = r_out_item;
        n_length_count = r_length_count;
        n_length_stop  = r_length_stop;
        n_env_start    = r_env_start;
        n_env_rising   = r_env_rising;
        n_env_period   = r_env_period;
        n_period_shift = r_period_shift;
        n_narrow       = r_narrow;
        n_div_sel      = r_div_sel;
        n_running      = r_running;
        n_env_count    = r_env_count;
        n_volume       = r_volume;
        n_countdown    = r_countdown;
        n_lfsr         = r_lfsr;
        n_acc          = r_acc;

        // result taken downstream
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_state = S_RESULT;
                unique case (r_item.operation)
                    OP_WRITE: begin
                        unique case (r_item.reg_select)
                            REG_LENGTH: begin
                                // saturate at zero when data exceeds full length
                                if (len_data > len_full_c) begin
                                    n_length_count = '0;
                                end else begin
                                    n_length_count = LEN_W'(len_full_c - len_data);
                                end
                            end
                            REG_ENVELOPE: begin
                                n_env_start  = r_item.write_data[7:4];
                                n_env_rising = r_item.write_data[3];
                                n_env_period = r_item.write_data[2:0];
                                // DAC off
                                if (r_item.write_data[7:3] == 5'd0) begin
                                    n_running = 1'b0;
                                end
                            end
                            REG_POLY: begin
                                n_period_shift = r_item.write_data[7:4];
                                n_narrow       = r_item.write_data[3];
                                n_div_sel      = r_item.write_data[2:0];
                            end
                            default: begin
                                n_length_stop = r_item.write_data[6];
                                if (r_item.write_data[7]) begin
                                    // trigger
                                    if (r_length_count == '0) begin
                                        n_length_count = LEN_W'(LENGTH_FULL);
                                    end
                                    n_env_count = r_env_period;
                                    n_volume    = r_env_start;
                                    n_countdown = CNT_W'(period);
                                    n_lfsr      = LFSR_SEED;
                                    n_running   = (r_env_start != 4'd0) || r_env_rising;
                                end
                            end
                        endcase
                    end
                    OP_TICK: begin
                        if (r_running) begin
                            n_acc   = ACC_W'(r_countdown) - ACC_W'(r_item.tick_cycles);
                            n_state = S_TICK;
                        end
                    end
                    OP_LENGTH: begin
                        if (r_length_stop && (r_length_count != '0)) begin
                            n_length_count = r_length_count - LEN_W'(1);
                            if (r_length_count == LEN_W'(1)) begin
                                n_running = 1'b0;
                            end
                        end
                    end
                    OP_ENVELOPE: begin
                        if (r_env_period != 3'd0) begin
                            n_env_count = env_count_dec;
                            if (env_count_dec == 3'd0) begin
                                n_env_count = r_env_period;
                                if (r_env_rising && (r_volume != VOL_MAX)) begin
                                    n_volume = r_volume + 4'd1;
                                end else if (!r_env_rising && (r_volume != 4'd0)) begin
                                    n_volume = r_volume - 4'd1;
                                end
                            end
                        end
                    end
                    default: ;  // read and unused codes change nothing
                endcase
            end

            S_TICK: begin
                // one timer expiry per cycle through the shared adder
                if (acc_le_zero) begin
                    n_acc  = r_acc + ACC_W'(period);
                    n_lfsr = lfsr_stepped;
                end else begin
                    n_countdown = r_acc[CNT_W-1:0];
                    n_state     = S_RESULT;
                end
            end

            default: begin
                // S_RESULT: wait for a free output register
                if (!r_out_valid || !i_stall) begin
                    n_out_valid          = 1'b1;
                    n_out_item.read_data = (r_item.operation == OP_READ) ? rd_value : 8'd0;
                    n_out_item.channel_on = r_running;
                    n_out_item.amplitude  = (r_running && !r_lfsr[0]) ? r_volume : 4'd0;
                    n_state              = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_length_count <= '0;
            r_length_stop  <= 1'b0;
            r_env_start    <= 4'd0;
            r_env_rising   <= 1'b0;
            r_env_period   <= 3'd0;
            r_period_shift <= 4'd0;
            r_narrow       <= 1'b0;
            r_div_sel      <= 3'd0;
            r_running      <= 1'b0;
            r_env_count    <= 3'd0;
            r_volume       <= 4'd0;
            r_countdown    <= '0;
            r_lfsr         <= '0;
        end else begin
            r_state        <= n_state;
            r_out_valid    <= n_out_valid;
            r_length_count <= n_length_count;
            r_length_stop  <= n_length_stop;
            r_env_start    <= n_env_start;
            r_env_rising   <= n_env_rising;
            r_env_period   <= n_env_period;
            r_period_shift <= n_period_shift;
            r_narrow       <= n_narrow;
            r_div_sel      <= n_div_sel;
            r_running      <= n_running;
            r_env_count    <= n_env_count;
            r_volume       <= n_volume;
            r_countdown    <= n_countdown;
            r_lfsr         <= n_lfsr;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
        r_acc      <= n_acc;
        if (r_state == S_IDLE && i_valid) begin
            r_item <= i_item;
        end
    end

    // a stalled result stays put
    `LNSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_item), "stalled result changed")
    // the tick loop only runs for a running channel
    `LNSC_ASSERT_NOW(a_tick_running, i_clk, i_rst_n, r_state == S_TICK, r_running,
        "tick loop while channel off")
    // an accepted item is executed in the next cycle
    `LNSC_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, i_valid && !o_stall,
        r_state == S_EXEC, "accepted item not executed")
    // a nonzero level is only reported for an enabled channel
    `LNSC_ASSERT_NOW(a_amp_on, i_clk, i_rst_n, o_valid && (o_item.amplitude != 4'd0),
        o_item.channel_on, "amplitude on a disabled channel")

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for the noise sound channel: in-order scoreboard with its own channel predictor.
`timescale 1ns / 1ps

module tb;
    import lnsc_pkg::*;

    localparam int unsigned LEN_FULL     = LENGTH_FULL_DEF;
    localparam int unsigned ITEM_TARGET  = 1850;
    localparam int unsigned CALM_TAIL    = 200;   // last items run with no idling
    localparam int unsigned LONG_HOLD    = 400;   // receiver hold-off, in cycles
    localparam int unsigned DRAIN_CYCLES = 60;    // longer than the slowest tick item

    // operation codes that the block ignores
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    // Scoreboard: runs the channel predictor on every accepted item and keeps
    // the expected results in order.
    class noise_scoreboard;
        t_out_item   pending_results[$];
        int unsigned errors;

        // predicted channel state
        logic [6:0]  len_count;
        logic        len_stop_en;
        logic [3:0]  env_start_vol;
        logic        env_up;
        logic [2:0]  env_period;
        logic [3:0]  per_shift;
        logic        narrow;
        logic [2:0]  div_sel;
        logic        running;
        logic [2:0]  env_count;
        logic [3:0]  volume;
        logic [22:0] per_count;
        logic [14:0] noise_lfsr;
        int unsigned div_tab[8];

        function new();
            div_tab = '{8, 16, 32, 48, 64, 80, 96, 112};
            errors = 0;
            len_count = '0;
            len_stop_en = 1'b0;
            env_start_vol = '0;
            env_up = 1'b0;
            env_period = '0;
            per_shift = '0;
            narrow = 1'b0;
            div_sel = '0;
            running = 1'b0;
            env_count = '0;
            volume = '0;
            per_count = '0;
            noise_lfsr = '0;
        endfunction

        function logic [22:0] cur_period();
            logic [22:0] base;
            base = 23'(div_tab[div_sel]);
            return base << per_shift;
        endfunction

        function void step_lfsr();
            logic fb;
            fb = noise_lfsr[0] ^ noise_lfsr[1];
            noise_lfsr = {fb, noise_lfsr[14:1]};
            if (narrow) noise_lfsr[6] = fb;
        endfunction

        function void restart_channel();
            running = 1'b1;
            if (len_count == 0) len_count = 7'(LEN_FULL);
            env_count = env_period;
            volume = env_start_vol;
            per_count = cur_period();
            noise_lfsr = LFSR_SEED;
            // DAC off: silent, non-rising envelope keeps the channel down
            if (env_start_vol == 4'd0 && !env_up) running = 1'b0;
        endfunction

        function void write_register(logic [1:0] sel, logic [7:0] d);
            case (sel)
                REG_LENGTH: begin
                    if (int'(d[5:0]) > int'(LEN_FULL)) len_count = '0;
                    else len_count = 7'(LEN_FULL - d[5:0]);
                end
                REG_ENVELOPE: begin
                    env_start_vol = d[7:4];
                    env_up = d[3];
                    env_period = d[2:0];
                    if (d[7:3] == 5'd0) running = 1'b0;
                end
                REG_POLY: begin
                    per_shift = d[7:4];
                    narrow = d[3];
                    div_sel = d[2:0];
                end
                default: begin
                    len_stop_en = d[6];
                    if (d[7]) restart_channel();
                end
            endcase
        endfunction

        function logic [7:0] read_register(logic [1:0] sel);
            case (sel)
                REG_LENGTH:   return RD_LENGTH;
                REG_ENVELOPE: return {env_start_vol, env_up, env_period};
                REG_POLY:     return {per_shift, narrow, div_sel};
                default:      return {1'b1, len_stop_en, RD_CTRL_LOW};
            endcase
        endfunction

        function void run_timer(logic [7:0] clocks);
            int t;
            if (!running) return;
            t = int'(per_count) - int'(clocks);
            while (t <= 0) begin
                t += int'(cur_period());
                step_lfsr();
            end
            per_count = 23'(t);
        endfunction

        function void length_clock();
            if (len_stop_en && len_count > 0) begin
                len_count--;
                if (len_count == 0) running = 1'b0;
            end
        endfunction

        function void envelope_clock();
            if (env_period == 3'd0) return;
            if (env_count > 0) env_count--;
            if (env_count == 0) begin
                env_count = env_period;
                if (env_up && volume < VOL_MAX) volume++;
                else if (!env_up && volume > 0) volume--;
            end
        endfunction

        // accepted input item: predict its result
        function void note_item(t_in_item it);
            t_out_item want;
            want.read_data = 8'h00;
            case (it.operation)
                OP_WRITE:    write_register(it.reg_select, it.write_data);
                OP_READ:     want.read_data = read_register(it.reg_select);
                OP_TICK:     run_timer(it.tick_cycles);
                OP_LENGTH:   length_clock();
                OP_ENVELOPE: envelope_clock();
                default: ;
            endcase
            want.channel_on = running;
            want.amplitude = (running && !noise_lfsr[0]) ? volume : 4'd0;
            pending_results.push_back(want);
        endfunction

        // accepted result item: compare with the oldest prediction
        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                $error("result with no item outstanding: %p", got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.read_data !== want.read_data) begin
                $error("read_data: expected %0h, actual %0h", want.read_data, got.read_data);
                errors++;
            end
            if (got.channel_on !== want.channel_on) begin
                $error("channel_on: expected %0b, actual %0b", want.channel_on, got.channel_on);
                errors++;
            end
            if (got.amplitude !== want.amplitude) begin
                $error("amplitude: expected %0d, actual %0d", want.amplitude, got.amplitude);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_item;

    noise_scoreboard sb = new();

    bit          idle_on = 1'b1;     // random gaps and stalls allowed
    bit          long_hold_req = 1'b0;
    int unsigned items_sent = 0;     // accepted input items

    lfsr_noise_sound_channel #(
        .LENGTH_FULL(LEN_FULL)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("lfsr_noise_sound_channel verification failed");
        $finish;
    end

    function automatic t_in_item mk_item(logic [2:0] op, logic [1:0] rs,
                                         logic [7:0] wd, logic [7:0] tc);
        t_in_item it;
        it.operation = op;
        it.reg_select = rs;
        it.write_data = wd;
        it.tick_cycles = tc;
        return it;
    endfunction

    // Offer one item and hold it until taken. All sampling happens right at
    // the edge, so every value read is the one the block saw.
    task automatic push_item(t_in_item it);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_item(it);
        items_sent++;
    endtask

    // Result side: checks at each edge, then decides the stall for the next.
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) sb.check_result(o_item);
            if (long_hold_req) begin
                // long hold-off: the block fills up and stalls its input
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 7);
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Stimulus
    initial begin
        logic [7:0]  d;
        logic [2:0]  op;
        int unsigned burst;
        int unsigned r;
        int unsigned drain;
        bit          hold_done;

        hold_done = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed part ---
        // read-back of every register straight after reset
        push_item(mk_item(OP_READ, REG_LENGTH, 8'hFF, 8'hFF));
        push_item(mk_item(OP_READ, REG_ENVELOPE, 8'h00, 8'h00));
        push_item(mk_item(OP_READ, REG_POLY, 8'hFF, 8'h00));
        push_item(mk_item(OP_READ, REG_CONTROL, 8'h00, 8'hFF));
        // tick and envelope clock while the channel is off
        push_item(mk_item(OP_TICK, REG_CONTROL, 8'hFF, 8'hFF));
        push_item(mk_item(OP_ENVELOPE, REG_LENGTH, 8'h00, 8'h00));
        // ignored operation codes
        push_item(mk_item(OP_UNUSED_FIRST, REG_CONTROL, 8'hFF, 8'hFF));
        push_item(mk_item(OP_UNUSED_LAST, REG_LENGTH, 8'h00, 8'h00));
        // trigger with the DAC off stays silent
        push_item(mk_item(OP_WRITE, REG_ENVELOPE, 8'h00, 8'h00));
        push_item(mk_item(OP_WRITE, REG_CONTROL, 8'h80, 8'h00));
        // proper start: loudest falling envelope, shortest period, full length
        push_item(mk_item(OP_WRITE, REG_ENVELOPE, 8'hF7, 8'h00));
        push_item(mk_item(OP_WRITE, REG_POLY, 8'h00, 8'h00));
        push_item(mk_item(OP_WRITE, REG_LENGTH, 8'h00, 8'h00));
        push_item(mk_item(OP_WRITE, REG_CONTROL, 8'hC0, 8'h00));
        push_item(mk_item(OP_TICK, REG_LENGTH, 8'h00, 8'h00));
        push_item(mk_item(OP_TICK, REG_LENGTH, 8'h00, 8'hFF));
        // period change in flight: the running countdown keeps its value
        push_item(mk_item(OP_WRITE, REG_POLY, 8'hFF, 8'h00));
        push_item(mk_item(OP_TICK, REG_LENGTH, 8'h00, 8'hFF));
        push_item(mk_item(OP_ENVELOPE, REG_LENGTH, 8'h00, 8'h00));
        push_item(mk_item(OP_READ, REG_CONTROL, 8'h00, 8'h00));
        // shortest length: one length clock ends the note
        push_item(mk_item(OP_WRITE, REG_LENGTH, 8'h3F, 8'h00));
        push_item(mk_item(OP_LENGTH, REG_LENGTH, 8'h00, 8'h00));
        // rising envelope, then DAC off while running
        push_item(mk_item(OP_WRITE, REG_ENVELOPE, 8'h19, 8'h00));
        push_item(mk_item(OP_WRITE, REG_CONTROL, 8'h80, 8'h00));
        push_item(mk_item(OP_ENVELOPE, REG_LENGTH, 8'h00, 8'h00));
        push_item(mk_item(OP_WRITE, REG_ENVELOPE, 8'h07, 8'h00));

        // --- random part ---
        while (items_sent < ITEM_TARGET) begin
            if (items_sent + CALM_TAIL >= ITEM_TARGET) idle_on = 1'b0;
            else idle_on = ($urandom_range(0, 4) != 0);
            if (!hold_done && items_sent > ITEM_TARGET / 3) begin
                long_hold_req = 1'b1;
                hold_done = 1'b1;
            end

            if ($urandom_range(0, 3) != 0) begin
                // well-formed note: set up, trigger, then play with it
                d = 8'($urandom_range(0, 255));
                if (d[7:3] == 5'd0 && $urandom_range(0, 3) != 0)
                    d[7:4] = 4'($urandom_range(1, 15));
                push_item(mk_item(OP_WRITE, REG_ENVELOPE, d, 8'($urandom_range(0, 255))));
                d = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 3) != 0) d[7:4] = 4'($urandom_range(0, 2));
                push_item(mk_item(OP_WRITE, REG_POLY, d, 8'($urandom_range(0, 255))));
                if ($urandom_range(0, 1) == 0) begin
                    d = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 1) == 0) d[5:0] = 6'($urandom_range(56, 63));
                    push_item(mk_item(OP_WRITE, REG_LENGTH, d, 8'($urandom_range(0, 255))));
                end
                d = 8'($urandom_range(0, 255));
                d[7] = 1'b1;
                push_item(mk_item(OP_WRITE, REG_CONTROL, d, 8'($urandom_range(0, 255))));

                burst = $urandom_range(10, 40);
                repeat (burst) begin
                    r = $urandom_range(0, 99);
                    if (r < 50) op = OP_TICK;
                    else if (r < 65) op = OP_READ;
                    else if (r < 75) op = OP_LENGTH;
                    else if (r < 90) op = OP_ENVELOPE;
                    else op = OP_WRITE;
                    push_item(mk_item(op, 2'($urandom_range(0, 3)),
                                      8'($urandom_range(0, 255)),
                                      8'($urandom_range(0, 255))));
                end
            end else begin
                // noise: any operation code, any field values
                burst = $urandom_range(5, 15);
                repeat (burst)
                    push_item(mk_item(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                                      8'($urandom_range(0, 255)),
                                      8'($urandom_range(0, 255))));
            end
        end

        i_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        // let any stray result show up before the verdict
        for (drain = 0; drain < DRAIN_CYCLES; drain++) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("lfsr_noise_sound_channel verification clean");
        else
            $display("lfsr_noise_sound_channel verification failed");
        $finish;
    end

endmodule
